/* design/bfrf_pkg.sv */
package bfrf_pkg;

    // largest payload index that is still delivered, plus one
    localparam int unsigned MAX_PAYLOAD = 512;

    // receiver phase codes
    localparam logic [3:0] PH_SYNC1 = 4'd0;
    localparam logic [3:0] PH_SYNC2 = 4'd1;
    localparam logic [3:0] PH_CLASS = 4'd2;
    localparam logic [3:0] PH_ID    = 4'd3;
    localparam logic [3:0] PH_LEN1  = 4'd4;
    localparam logic [3:0] PH_LEN2  = 4'd5;
    localparam logic [3:0] PH_DATA  = 4'd6;
    localparam logic [3:0] PH_CKA   = 4'd7;
    localparam logic [3:0] PH_CKB   = 4'd8;

    // frame status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CHECKSUM = 2'd1;
    localparam logic [1:0] ST_UNKNOWN  = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // acknowledge event codes
    localparam logic [1:0] ACK_NONE = 2'd0;
    localparam logic [1:0] ACK_POS  = 2'd1;
    localparam logic [1:0] ACK_NEG  = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] REG_SYNC_FIRST  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SYNC_SECOND = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ACK_CLASS   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ACK_ID      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_NAK_ID      = 3'd4;

    localparam int unsigned TDATA_W = 64;

    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
        logic [7:0] ack_class;
        logic [7:0] ack_id;
        logic [7:0] nak_id;
    } t_cfg;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic        frame_done;
        logic [1:0]  frame_status;
        logic [7:0]  msg_class;
        logic [7:0]  msg_id;
        logic [15:0] msg_length;
        logic [1:0]  ack_event;
    } t_result;

    // standard class codes, the programmable ack class is checked separately
    function automatic logic class_std(input logic [7:0] c);
        logic hit;
        case (c)
            8'h01, 8'h02, 8'h04, 8'h05, 8'h06, 8'h09, 8'h0A,
            8'h0B, 8'h0D, 8'h10, 8'h13, 8'h21, 8'h27, 8'h28: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

/* design/binary_frame_receiver_fletcher_top.sv */
// Binary frame receiver with an 8-bit Fletcher check. Each byte taken on the
// slave side gives exactly one result on the master side. The phase machine
// and check sums update on each accepted byte, so a byte can be taken on
// every clock unless input stalls. A two-entry output register and skid stage
// let input continue while a result waits; input stalls only when both are
// full. The receiver hunts for the two sync bytes, captures class, id and
// little-endian length, streams payload bytes (tuser high) with their index,
// and on the second check byte raises tlast with the frame status (ok,
// checksum error, unknown class, overflow past 512 payload bytes) and the
// ack or nak event of good frames. The configuration registers (sync bytes,
// ack class, ack and nak ids) take effect on the next byte; they must be
// written only while the stream is idle, which the block does not enforce.
module binary_frame_receiver_fletcher_top
    import bfrf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [7:0]            i_cfg_wdata,
    // received bytes
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [7:0]            i_s_axis_tdata,   // rx_byte
    // results
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // payload_byte, payload_index, frame_status, msg_class, msg_id,
    // msg_length, ack_event, zero fill
    output logic [TDATA_W-1:0]    o_m_axis_tdata,
    output logic                  o_m_axis_tlast,   // frame_done
    output logic                  o_m_axis_tuser    // payload_valid
);

    t_cfg    cfg;
    t_result result;
    t_result out_res;
    logic    accept;

    assign accept = i_s_axis_tvalid && o_s_axis_tready;

    bfrf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    bfrf_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_axis_tdata),
        .i_cfg    (cfg),
        .o_result (result)
    );

    bfrf_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_data  (result),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (out_res)
    );

    // pack result fields, lowest first
    assign o_m_axis_tdata = {4'd0,
                             out_res.ack_event,
                             out_res.msg_length,
                             out_res.msg_id,
                             out_res.msg_class,
                             out_res.frame_status,
                             out_res.payload_index,
                             out_res.payload_byte};
    assign o_m_axis_tlast = out_res.frame_done;
    assign o_m_axis_tuser = out_res.payload_valid;

endmodule

/* design/bfrf_cfg.sv */
module bfrf_cfg
    import bfrf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [7:0]            i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // register file, writes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first  <= 8'd181;
            r_cfg.sync_second <= 8'd98;
            r_cfg.ack_class   <= 8'd5;
            r_cfg.ack_id      <= 8'd1;
            r_cfg.nak_id      <= 8'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_SYNC_FIRST:  r_cfg.sync_first  <= i_cfg_wdata;
                REG_SYNC_SECOND: r_cfg.sync_second <= i_cfg_wdata;
                REG_ACK_CLASS:   r_cfg.ack_class   <= i_cfg_wdata;
                REG_ACK_ID:      r_cfg.ack_id      <= i_cfg_wdata;
                REG_NAK_ID:      r_cfg.nak_id      <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* design/bfrf_parse.sv */
module bfrf_parse
    import bfrf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  t_cfg       i_cfg,
    output t_result    o_result
);

    logic [3:0]  r_phase,    n_phase;
    logic [7:0]  r_class,    n_class;
    logic [7:0]  r_id,       n_id;
    logic [15:0] r_length,   n_length;
    logic [15:0] r_pos,      n_pos;
    logic [7:0]  r_sum_a,    n_sum_a;
    logic [7:0]  r_sum_b,    n_sum_b;
    logic [7:0]  r_check_a,  n_check_a;
    logic        r_overflow, n_overflow;

    logic [7:0]  sum_a_add;
    logic [7:0]  sum_b_add;
    logic [15:0] pos_inc;
    logic        class_ok;
    t_result     res;

    // running fletcher pair with the current byte
    assign sum_a_add = r_sum_a + i_byte;
    assign sum_b_add = r_sum_b + sum_a_add;
    assign pos_inc   = r_pos + 16'd1;
    assign class_ok  = class_std(r_class) || (r_class == i_cfg.ack_class);

    // next state and result for the byte on the input
    always_comb begin
        n_phase    = r_phase;
        n_class    = r_class;
        n_id       = r_id;
        n_length   = r_length;
        n_pos      = r_pos;
        n_sum_a    = r_sum_a;
        n_sum_b    = r_sum_b;
        n_check_a  = r_check_a;
        n_overflow = r_overflow;
        res        = '0;
        case (r_phase)
            PH_SYNC1: begin
                if (i_byte == i_cfg.sync_first) n_phase = PH_SYNC2;
            end
            PH_SYNC2: begin
                if (i_byte == i_cfg.sync_second) begin
                    n_phase    = PH_CLASS;
                    n_sum_a    = 8'd0;
                    n_sum_b    = 8'd0;
                    n_overflow = 1'b0;
                    n_pos      = 16'd0;
                end else begin
                    n_phase = PH_SYNC1;
                end
            end
            PH_CLASS: begin
                n_class = i_byte;
                n_sum_a = sum_a_add;
                n_sum_b = sum_b_add;
                n_phase = PH_ID;
            end
            PH_ID: begin
                n_id    = i_byte;
                n_sum_a = sum_a_add;
                n_sum_b = sum_b_add;
                n_phase = PH_LEN1;
            end
            PH_LEN1: begin
                n_length = {8'd0, i_byte};
                n_sum_a  = sum_a_add;
                n_sum_b  = sum_b_add;
                n_phase  = PH_LEN2;
            end
            PH_LEN2: begin
                n_length = {i_byte, r_length[7:0]};
                n_sum_a  = sum_a_add;
                n_sum_b  = sum_b_add;
                n_pos    = 16'd0;
                n_phase  = ({i_byte, r_length[7:0]} == 16'd0) ? PH_CKA : PH_DATA;
            end
            PH_DATA: begin
                n_sum_a = sum_a_add;
                n_sum_b = sum_b_add;
                if (r_pos >= 16'(MAX_PAYLOAD)) begin
                    n_overflow = 1'b1;
                end else begin
                    res.payload_valid = 1'b1;
                    res.payload_byte  = i_byte;
                    res.payload_index = r_pos;
                end
                n_pos = pos_inc;
                if (pos_inc == r_length) n_phase = PH_CKA;
            end
            PH_CKA: begin
                n_check_a = i_byte;
                n_phase   = PH_CKB;
            end
            PH_CKB: begin
                res.frame_done = 1'b1;
                if (r_overflow) begin
                    res.frame_status = ST_OVERFLOW;
                end else if (r_check_a != r_sum_a || i_byte != r_sum_b) begin
                    res.frame_status = ST_CHECKSUM;
                end else if (!class_ok) begin
                    res.frame_status = ST_UNKNOWN;
                end else begin
                    res.frame_status = ST_OK;
                    if (r_class == i_cfg.ack_class) begin
                        if (r_id == i_cfg.ack_id)      res.ack_event = ACK_POS;
                        else if (r_id == i_cfg.nak_id) res.ack_event = ACK_NEG;
                        else                           res.ack_event = ACK_NONE;
                    end
                end
                n_phase = PH_SYNC1;
            end
            default: begin
                n_phase = PH_SYNC1;
            end
        endcase
        res.msg_class  = n_class;
        res.msg_id     = n_id;
        res.msg_length = n_length;
    end

    // state update on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SYNC1;
            r_class    <= 8'd0;
            r_id       <= 8'd0;
            r_length   <= 16'd0;
            r_pos      <= 16'd0;
            r_sum_a    <= 8'd0;
            r_sum_b    <= 8'd0;
            r_check_a  <= 8'd0;
            r_overflow <= 1'b0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_class    <= n_class;
            r_id       <= n_id;
            r_length   <= n_length;
            r_pos      <= n_pos;
            r_sum_a    <= n_sum_a;
            r_sum_b    <= n_sum_b;
            r_check_a  <= n_check_a;
            r_overflow <= n_overflow;
        end
    end

    assign o_result = res;

endmodule

/* design/bfrf_skid.sv */
module bfrf_skid
    import bfrf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    take;
    logic    put;

    assign take    = r_out_valid && i_ready;
    assign o_ready = !r_skid_valid;
    assign put     = i_valid && !r_skid_valid;

    // valid flags of the output register and the skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) r_skid_valid <= 1'b0;
        end else if (put) begin
            if (r_out_valid && !take) r_skid_valid <= 1'b1;
            else                      r_out_valid  <= 1'b1;
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload moves
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) r_out <= r_skid;
        end else if (put) begin
            if (r_out_valid && !take) r_skid <= i_data;
            else                      r_out  <= i_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

/* tb/frame_parse_checker.sv */
`timescale 1ns / 100ps

module frame_parse_checker
    import bfrf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [7:0]            i_cfg_wdata,
    input  logic                  i_s_axis_tvalid,
    input  logic                  i_s_axis_tready,
    input  logic [7:0]            i_s_axis_tdata,   // rx_byte
    input  logic                  i_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // payload_byte, payload_index, frame_status, msg_class, msg_id,
    // msg_length, ack_event, zero fill
    input  logic [TDATA_W-1:0]    i_m_axis_tdata,
    input  logic                  i_m_axis_tlast,   // frame_done
    input  logic                  i_m_axis_tuser,   // payload_valid
    output int                    o_fail_count,
    output int                    o_pending_count
);

    localparam t_cfg CFG_AFTER_RESET = '{8'd181, 8'd98, 8'd5, 8'd1, 8'd0};

    // own copy of the settings and of the parser state
    t_cfg        cfg;
    logic [3:0]  phase;
    logic [7:0]  frame_class;
    logic [7:0]  frame_id;
    logic [15:0] frame_length;
    logic [15:0] byte_pos;
    logic [7:0]  sum_a;
    logic [7:0]  sum_b;
    logic [7:0]  check_a;
    logic        overflow_seen;

    // frame results still to come out, oldest first
    t_result     expected_results[$];

    function automatic logic known_class(input logic [7:0] c);
        return (c == cfg.ack_class) || (c inside {8'h01, 8'h02, 8'h04, 8'h05, 8'h06,
            8'h09, 8'h0A, 8'h0B, 8'h0D, 8'h10, 8'h13, 8'h21, 8'h27, 8'h28});
    endfunction

    function automatic string fmt_result(input t_result r);
        return $sformatf({"valid=%0d byte=%02h index=%0d done=%0d status=%0d ",
                          "class=%02h id=%02h len=%0d ack=%0d"},
            r.payload_valid, r.payload_byte, r.payload_index, r.frame_done,
            r.frame_status, r.msg_class, r.msg_id, r.msg_length, r.ack_event);
    endfunction

    task automatic fletcher_add(input logic [7:0] b);
        sum_a = sum_a + b;
        sum_b = sum_b + sum_a;
    endtask

    // advance the parser by one received byte and give the result it causes
    task automatic parse_byte(input logic [7:0] b, output t_result r);
        r = '0;
        r.frame_status = ST_OK;
        r.ack_event = ACK_NONE;
        case (phase)
            PH_SYNC1: begin
                if (b == cfg.sync_first) phase = PH_SYNC2;
            end
            PH_SYNC2: begin
                if (b == cfg.sync_second) begin
                    phase = PH_CLASS;
                    sum_a = '0;
                    sum_b = '0;
                    overflow_seen = 1'b0;
                    byte_pos = '0;
                end else begin
                    phase = PH_SYNC1;
                end
            end
            PH_CLASS: begin
                frame_class = b;
                fletcher_add(b);
                phase = PH_ID;
            end
            PH_ID: begin
                frame_id = b;
                fletcher_add(b);
                phase = PH_LEN1;
            end
            PH_LEN1: begin
                frame_length = {8'h00, b};
                fletcher_add(b);
                phase = PH_LEN2;
            end
            PH_LEN2: begin
                frame_length[15:8] = b;
                fletcher_add(b);
                byte_pos = '0;
                phase = (frame_length == 16'd0) ? PH_CKA : PH_DATA;
            end
            PH_DATA: begin
                fletcher_add(b);
                // bytes past the payload limit are summed but not delivered
                if (byte_pos >= MAX_PAYLOAD) begin
                    overflow_seen = 1'b1;
                end else begin
                    r.payload_valid = 1'b1;
                    r.payload_byte = b;
                    r.payload_index = byte_pos;
                end
                byte_pos = byte_pos + 16'd1;
                if (byte_pos == frame_length) phase = PH_CKA;
            end
            PH_CKA: begin
                check_a = b;
                phase = PH_CKB;
            end
            PH_CKB: begin
                r.frame_done = 1'b1;
                if (overflow_seen) begin
                    r.frame_status = ST_OVERFLOW;
                end else if (check_a != sum_a || b != sum_b) begin
                    r.frame_status = ST_CHECKSUM;
                end else if (!known_class(frame_class)) begin
                    r.frame_status = ST_UNKNOWN;
                end else if (frame_class == cfg.ack_class) begin
                    if (frame_id == cfg.ack_id) r.ack_event = ACK_POS;
                    else if (frame_id == cfg.nak_id) r.ack_event = ACK_NEG;
                end
                phase = PH_SYNC1;
            end
            default: begin
                phase = PH_SYNC1;
            end
        endcase
        r.msg_class = frame_class;
        r.msg_id = frame_id;
        r.msg_length = frame_length;
    endtask

    // compare results, follow register writes, predict from accepted bytes
    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            cfg = CFG_AFTER_RESET;
            phase = PH_SYNC1;
            frame_class = '0;
            frame_id = '0;
            frame_length = '0;
            byte_pos = '0;
            sum_a = '0;
            sum_b = '0;
            check_a = '0;
            overflow_seen = 1'b0;
            expected_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.payload_valid = i_m_axis_tuser;
                got.payload_byte  = i_m_axis_tdata[7:0];
                got.payload_index = i_m_axis_tdata[23:8];
                got.frame_done    = i_m_axis_tlast;
                got.frame_status  = i_m_axis_tdata[25:24];
                got.msg_class     = i_m_axis_tdata[33:26];
                got.msg_id        = i_m_axis_tdata[41:34];
                got.msg_length    = i_m_axis_tdata[57:42];
                got.ack_event     = i_m_axis_tdata[59:58];
                if (expected_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t result with no request pending: %s", $realtime,
                            fmt_result(got));
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("%0t result mismatch\n  expected %s\n  actual   %s",
                                $realtime, fmt_result(want), fmt_result(got));
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_SYNC_FIRST:  cfg.sync_first  = i_cfg_wdata;
                    REG_SYNC_SECOND: cfg.sync_second = i_cfg_wdata;
                    REG_ACK_CLASS:   cfg.ack_class   = i_cfg_wdata;
                    REG_ACK_ID:      cfg.ack_id      = i_cfg_wdata;
                    REG_NAK_ID:      cfg.nak_id      = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                parse_byte(i_s_axis_tdata, want);
                expected_results.push_back(want);
            end
        end
        o_pending_count = expected_results.size();
    end

endmodule

/* tb/binary_frame_receiver_fletcher_top_test.sv */
`timescale 1ns / 100ps

module binary_frame_receiver_fletcher_top_test;
    import bfrf_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [7:0]            cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;
    int                    fail_count;
    int                    pending_count;

    // stimulus side bookkeeping
    t_cfg                  cur_cfg;
    int                    sender_idle_pct = 0;
    int                    recv_stall_pct = 0;
    int                    bytes_sent = 0;
    logic [7:0]            run_a;
    logic [7:0]            run_b;

    binary_frame_receiver_fletcher_top i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .o_m_axis_tuser  (m_tuser)
    );

    frame_parse_checker frame_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_m_axis_tlast  (m_tlast),
        .i_m_axis_tuser  (m_tuser),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end

    // result side back-pressure
    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic drive_byte(input logic [7:0] b);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        bytes_sent++;
    endtask

    // byte that is covered by the check sums
    task automatic send_summed(input logic [7:0] b);
        run_a = run_a + b;
        run_b = run_b + run_a;
        drive_byte(b);
    endtask

    // frame whose length field may differ from the payload actually sent
    task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                              input int declared, input int sent, input bit corrupt);
        logic [7:0] cka;
        logic [7:0] ckb;
        run_a = '0;
        run_b = '0;
        drive_byte(cur_cfg.sync_first);
        drive_byte(cur_cfg.sync_second);
        send_summed(cls);
        send_summed(id);
        send_summed(declared[7:0]);
        send_summed(declared[15:8]);
        repeat (sent) send_summed(8'($urandom));
        cka = run_a;
        ckb = run_b;
        if (corrupt) begin
            if ($urandom_range(1)) cka = cka ^ (8'd1 << $urandom_range(7));
            else ckb = ckb ^ (8'd1 << $urandom_range(7));
        end
        drive_byte(cka);
        drive_byte(ckb);
    endtask

    function automatic logic [7:0] std_class();
        logic [7:0] c;
        case ($urandom_range(13))
            0:  c = 8'h01;
            1:  c = 8'h02;
            2:  c = 8'h04;
            3:  c = 8'h05;
            4:  c = 8'h06;
            5:  c = 8'h09;
            6:  c = 8'h0A;
            7:  c = 8'h0B;
            8:  c = 8'h0D;
            9:  c = 8'h10;
            10: c = 8'h13;
            11: c = 8'h21;
            12: c = 8'h27;
            default: c = 8'h28;
        endcase
        return c;
    endfunction

    // mostly well-formed short frames, with some noise and damaged frames
    task automatic random_frame();
        logic [7:0] cls;
        logic [7:0] id;
        int k;
        int len;
        int sent;
        bit corrupt;
        k = $urandom_range(99);
        if (k < 15) begin
            repeat ($urandom_range(4, 1)) drive_byte(8'($urandom));
        end else if (k < 25) begin
            // first sync followed by a wrong second sync
            drive_byte(cur_cfg.sync_first);
            drive_byte(cur_cfg.sync_second ^ 8'($urandom_range(255, 1)));
        end
        k = $urandom_range(99);
        if (k < 45) cls = std_class();
        else if (k < 70) cls = cur_cfg.ack_class;
        else cls = 8'($urandom);
        case ($urandom_range(2))
            0: id = cur_cfg.ack_id;
            1: id = cur_cfg.nak_id;
            default: id = 8'($urandom);
        endcase
        len = ($urandom_range(9) == 0) ? 0 : $urandom_range(12, 1);
        sent = len;
        if ($urandom_range(19) == 0) begin
            sent = len + $urandom_range(2) - 1;
            if (sent < 0) sent = 0;
        end
        corrupt = ($urandom_range(6) == 0);
        send_frame(cls, id, len, sent, corrupt);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [7:0] data);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    task automatic load_settings(input t_cfg c);
        write_reg(REG_SYNC_FIRST, c.sync_first);
        write_reg(REG_SYNC_SECOND, c.sync_second);
        write_reg(REG_ACK_CLASS, c.ack_class);
        write_reg(REG_ACK_ID, c.ack_id);
        write_reg(REG_NAK_ID, c.nak_id);
        cfg_we <= 1'b0;
        @(posedge clk);
        cur_cfg = c;
    endtask

    // stop sending and let every outstanding result drain
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
    endtask

    function automatic t_cfg phase_settings(input int p);
        t_cfg c;
        c.sync_first  = 8'($urandom);
        c.sync_second = 8'($urandom);
        c.ack_class   = 8'($urandom);
        c.ack_id      = 8'($urandom);
        c.nak_id      = 8'($urandom);
        case (p)
            1: c = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF};
            2: c = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00};
            3: c.nak_id = c.ack_id;
            default: begin
                c.sync_second = c.sync_first;
                c.ack_class = 8'h28;
            end
        endcase
        return c;
    endfunction

    // stimulus and verdict
    initial begin
        int phase_end;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cur_cfg = '{8'd181, 8'd98, 8'd5, 8'd1, 8'd0};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // wrong second sync that is itself the first sync, then a lone second sync
        drive_byte(cur_cfg.sync_first);
        drive_byte(cur_cfg.sync_first);
        drive_byte(cur_cfg.sync_second);
        // empty acknowledge frames, then an unknown class with one payload byte
        send_frame(cur_cfg.ack_class, cur_cfg.ack_id, 0, 0, 1'b0);
        send_frame(cur_cfg.ack_class, cur_cfg.nak_id, 0, 0, 1'b0);
        send_frame(8'hFF, 8'h00, 1, 1, 1'b0);

        for (int p = 0; p < 5; p++) begin
            if (p > 0) begin
                drain();
                load_settings(phase_settings(p));
            end
            case (p)
                1: begin
                    sender_idle_pct = 46;
                    recv_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    recv_stall_pct = 46;
                end
                3: begin
                    sender_idle_pct = 34;
                    recv_stall_pct = 34;
                end
                default: begin
                    sender_idle_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            if (p == 1) begin
                // payload that fills the limit and then runs past it
                send_frame(std_class(), 8'($urandom), MAX_PAYLOAD + 2, MAX_PAYLOAD + 2, 1'b0);
            end
            phase_end = bytes_sent + 90;
            while (bytes_sent < phase_end) random_frame();
        end

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
